// ===== design/blfifo_pkg.sv =====
// Package for the backlog FIFO with watermark backpressure.
// Holds the event kinds, register map and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package blfifo_pkg;

  // Default number of backlog entries
  localparam int unsigned BacklogDepthDef = 16;

  // Field widths
  localparam int unsigned RefW   = 16;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned ChunkW = 32;
  localparam int unsigned UpperW = 5;
  localparam int unsigned LowerW = 4;

  // Threshold register reset values
  localparam logic [UpperW-1:0] UpperRst = 5'd1;
  localparam logic [LowerW-1:0] LowerRst = 4'd0;

  // Register map (index taken from paddr[2])
  typedef enum logic {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } reg_idx_e;

  // Event kinds
  typedef enum logic [1:0] {
    KIND_FULL   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_DRAIN  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

endpackage

// ===== design/backlog_fifo_watermark_backpressure.sv =====
// Backlog FIFO of buffer descriptors with a pending-retry tag and
// hysteresis backpressure. Depends on blfifo_pkg.
`timescale 1ns / 1ps

// Usage:
//   Events enter on start/kind_i with the buffer fields; busy is always low,
//   so one event can be issued every clock cycle.
//   Each event yields exactly one result via the input and result registers:
//   done_o pulses for one cycle with the result fields on their ports. The
//   receiver cannot stall; results must be taken in the cycle they appear.
//   Stage one registers the event, stage two reads the FIFO head, updates
//   pointers, count, pending tag and pressure flag, and registers the result.
//   The FIFO head entry is prefetched into a read register from the storage
//   array (one write port at the tail, one registered read port at the next
//   head), with a bypass when the written entry becomes the head.
//   Thresholds are set over the APB-style port (upper 0x0, lower 0x4) by the
//   user only while no event is in flight; not enforced. pready is tied high.
//   Reset clears pointers, count, pending tag, pressure flag and thresholds
//   (upper 1, lower 0) at once; the storage array needs no clearing since
//   only counted entries are ever read.
//   Throughput: one event per cycle.
module backlog_fifo_watermark_backpressure
  import blfifo_pkg::*;
#(
  parameter int unsigned BACKLOG_DEPTH = BacklogDepthDef,
  localparam int unsigned PtrW = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(BACKLOG_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // event channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [RefW-1:0]   buffer_ref_i,
  input  logic [SeqW-1:0]   seq_number_i,
  input  logic [ChunkW-1:0] chunk_number_i,
  // result channel
  output logic              done_o,
  output logic              out_valid_o,
  output logic [RefW-1:0]   out_ref_o,
  output logic [SeqW-1:0]   out_seq_o,
  output logic [ChunkW-1:0] out_chunk_o,
  output logic              apply_pulse_o,
  output logic              release_pulse_o,
  output logic              pressure_on_o,
  output logic [CntW-1:0]   backlog_count_o,
  output logic              backlog_empty_o,
  output logic              overflow_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CmpW  = (CntW > UpperW) ? CntW : UpperW;
  localparam int unsigned EntW  = RefW + SeqW + ChunkW;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(BACKLOG_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(BACKLOG_DEPTH);

  // ---------------- configuration registers ----------------
  logic [UpperW-1:0] upper_q;
  logic [LowerW-1:0] lower_q;
  reg_idx_e          reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UpperRst;
      lower_q <= LowerRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_UPPER: upper_q <= pwdata[UpperW-1:0];
        REG_LOWER: lower_q <= pwdata[LowerW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UPPER: prdata = 32'(upper_q);
      REG_LOWER: prdata = 32'(lower_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  assign busy = 1'b0;

  logic              in_v_q;
  kind_e             kind_q;
  logic [RefW-1:0]   ref_q;
  logic [SeqW-1:0]   seq_q;
  logic [ChunkW-1:0] chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      kind_q  <= kind_e'(kind_i);
      ref_q   <= buffer_ref_i;
      seq_q   <= seq_number_i;
      chunk_q <= chunk_number_i;
    end
  end

  // ---------------- backlog state ----------------
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pend_v_q, pend_v_d;
  logic [SeqW-1:0]   pend_seq_q, pend_seq_d;
  logic [ChunkW-1:0] pend_chunk_q, pend_chunk_d;
  logic              press_q, press_d;

  // storage and prefetched head entry
  logic [EntW-1:0]   mem [BACKLOG_DEPTH];
  logic [EntW-1:0]   head_ent_q;
  logic [EntW-1:0]   in_ent;
  logic              push;

  assign in_ent = {ref_q, seq_q, chunk_q};

  // ---------------- event logic ----------------
  logic              match, push_ok, pop, ovf, apply, rel;
  logic [CntW-1:0]   cnt_push;
  logic [EntW-1:0]   pop_ent, res_ent;
  logic              res_v;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    pend_v_d     = pend_v_q;
    pend_seq_d   = pend_seq_q;
    pend_chunk_d = pend_chunk_q;
    press_d      = press_q;
    push         = 1'b0;
    pop          = 1'b0;
    ovf          = 1'b0;
    apply        = 1'b0;
    rel          = 1'b0;
    res_v        = 1'b0;
    res_ent      = '0;
    match        = pend_v_q && (seq_q == pend_seq_q) && (chunk_q == pend_chunk_q);
    push_ok      = (cnt_q != FullCnt);
    cnt_push     = cnt_q + CntW'(push_ok);
    // an empty backlog pops the entry pushed by this same event
    pop_ent      = (cnt_q == '0) ? in_ent : head_ent_q;

    if (in_v_q) begin
      case (kind_q)
        KIND_FULL: begin
          if (match) begin
            res_v   = 1'b1;
            res_ent = in_ent;
          end else begin
            push = push_ok;
            ovf  = !push_ok;
            if (!press_q && (CmpW'(cnt_push) >= CmpW'(upper_q))) begin
              press_d = 1'b1;
              apply   = 1'b1;
            end
            if (!pend_v_q && (cnt_push != '0)) begin
              pop          = 1'b1;
              res_v        = 1'b1;
              res_ent      = pop_ent;
              pend_v_d     = 1'b1;
              pend_seq_d   = pop_ent[SeqW+ChunkW-1:ChunkW];
              pend_chunk_d = pop_ent[ChunkW-1:0];
            end
          end
        end
        KIND_OK: begin
          pend_v_d     = 1'b0;
          pend_seq_d   = '0;
          pend_chunk_d = '0;
          if (press_q && (CmpW'(cnt_q) <= CmpW'(lower_q))) begin
            press_d = 1'b0;
            rel     = 1'b1;
          end
          if (cnt_q != '0) begin
            pop     = 1'b1;
            res_v   = 1'b1;
            res_ent = head_ent_q;
          end
        end
        KIND_DRAIN: begin
          if (cnt_q != '0) begin
            pop     = 1'b1;
            res_v   = 1'b1;
            res_ent = head_ent_q;
          end
        end
        default: ;
      endcase
    end

    // pointer and count update
    if (push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + PtrW'(1);
    end
    if (pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      pend_v_q     <= 1'b0;
      pend_seq_q   <= '0;
      pend_chunk_q <= '0;
      press_q      <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      cnt_q        <= cnt_d;
      pend_v_q     <= pend_v_d;
      pend_seq_q   <= pend_seq_d;
      pend_chunk_q <= pend_chunk_d;
      press_q      <= press_d;
    end
  end

  // storage write at the tail
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[tail_q] <= in_ent;
    end
  end

  // prefetch the entry at the next head, forwarding a write to that slot
  always_ff @(posedge clk_i) begin
    if (push && (tail_q == head_d)) begin
      head_ent_q <= in_ent;
    end else begin
      head_ent_q <= mem[head_d];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_q) begin
      out_valid_o     <= res_v;
      out_ref_o       <= res_ent[EntW-1:SeqW+ChunkW];
      out_seq_o       <= res_ent[SeqW+ChunkW-1:ChunkW];
      out_chunk_o     <= res_ent[ChunkW-1:0];
      apply_pulse_o   <= apply;
      release_pulse_o <= rel;
      pressure_on_o   <= press_d;
      backlog_count_o <= cnt_d;
      backlog_empty_o <= (cnt_d == '0);
      overflow_o      <= ovf;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench for backlog_fifo_watermark_backpressure: drives random and directed
// events and APB threshold writes, and checks every result against a mirror.
// Depends on blfifo_pkg and the backlog_fifo_watermark_backpressure RTL.
`timescale 1ns / 1ps

module tb;
  import blfifo_pkg::*;

  localparam int unsigned Depth = BacklogDepthDef;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned NumPhases = 7;
  localparam int unsigned ItemsPerPhase = 86;

  // One result as seen on the output ports
  typedef struct packed {
    logic              valid;
    logic [RefW-1:0]   buf_ref;
    logic [SeqW-1:0]   seq;
    logic [ChunkW-1:0] chunk;
    logic              apply;
    logic              rel;
    logic              pressure;
    logic [4:0]        count;
    logic              empty;
    logic              ovf;
  } result_t;

  // Mirror of the backlog state; predicts one result per event and holds
  // the results still due from the block.
  class backlog_mirror;
    logic [RefW-1:0]   refs[Depth];
    logic [SeqW-1:0]   seqs[Depth];
    logic [ChunkW-1:0] chunks[Depth];
    int unsigned       head, tail;
    logic [4:0]        count;
    logic              pend_valid;
    logic [SeqW-1:0]   pend_seq;
    logic [ChunkW-1:0] pend_chunk;
    logic              pressure;
    logic [UpperW-1:0] upper;
    logic [LowerW-1:0] lower;
    result_t           due_results[$];
    int                mismatches;

    function new();
      head = 0;
      tail = 0;
      count = '0;
      pend_valid = 1'b0;
      pend_seq = '0;
      pend_chunk = '0;
      pressure = 1'b0;
      upper = UpperRst;
      lower = LowerRst;
      mismatches = 0;
    endfunction

    function void set_threshold(reg_idx_e idx, logic [31:0] value);
      if (idx == REG_UPPER) upper = value[UpperW-1:0];
      else lower = value[LowerW-1:0];
    endfunction

    // Take the head entry, if any, into the result
    function void pop_head(inout result_t r);
      if (count == 0) return;
      r.valid = 1'b1;
      r.buf_ref = refs[head];
      r.seq = seqs[head];
      r.chunk = chunks[head];
      head = (head + 1 == Depth) ? 0 : head + 1;
      count--;
    endfunction

    // Accepted event: update the mirror and queue the result it causes
    function void apply_event(logic [1:0] kind, logic [RefW-1:0] r, logic [SeqW-1:0] s,
                              logic [ChunkW-1:0] c);
      result_t e;
      e = '0;
      case (kind_e'(kind))
        KIND_FULL: begin
          if (pend_valid && s == pend_seq && c == pend_chunk) begin
            // retry of the pending buffer goes straight back
            e.valid = 1'b1;
            e.buf_ref = r;
            e.seq = s;
            e.chunk = c;
          end else begin
            if (count < Depth) begin
              refs[tail] = r;
              seqs[tail] = s;
              chunks[tail] = c;
              tail = (tail + 1 == Depth) ? 0 : tail + 1;
              count++;
            end else begin
              e.ovf = 1'b1;
            end
            if (!pressure && count >= upper) begin
              pressure = 1'b1;
              e.apply = 1'b1;
            end
            if (!pend_valid && count != 0) begin
              pop_head(e);
              pend_valid = 1'b1;
              pend_seq = e.seq;
              pend_chunk = e.chunk;
            end
          end
        end
        KIND_OK: begin
          pend_valid = 1'b0;
          pend_seq = '0;
          pend_chunk = '0;
          if (pressure && count <= lower) begin
            pressure = 1'b0;
            e.rel = 1'b1;
          end
          pop_head(e);
        end
        KIND_DRAIN: pop_head(e);
        default: ;
      endcase
      e.pressure = pressure;
      e.count = count;
      e.empty = (count == 0);
      due_results.push_back(e);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b1;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      return 1'b0;
    endfunction

    // Result from the block: compare with the oldest prediction
    function void match_result(result_t got);
      result_t want;
      bit ok;
      if (due_results.size() == 0) begin
        $display("%0t: result with no event outstanding, expected none got ref %0h seq %0h",
                 $time, got.buf_ref, got.seq);
        mismatches++;
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      ok = 1'b1;
      ok &= field_ok("out_valid", 32'(want.valid), 32'(got.valid));
      ok &= field_ok("out_ref", 32'(want.buf_ref), 32'(got.buf_ref));
      ok &= field_ok("out_seq", want.seq, got.seq);
      ok &= field_ok("out_chunk", want.chunk, got.chunk);
      ok &= field_ok("apply_pulse", 32'(want.apply), 32'(got.apply));
      ok &= field_ok("release_pulse", 32'(want.rel), 32'(got.rel));
      ok &= field_ok("pressure_on", 32'(want.pressure), 32'(got.pressure));
      ok &= field_ok("backlog_count", 32'(want.count), 32'(got.count));
      ok &= field_ok("backlog_empty", 32'(want.empty), 32'(got.empty));
      ok &= field_ok("overflow", 32'(want.ovf), 32'(got.ovf));
      if (!ok) mismatches++;
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [RefW-1:0]   buffer_ref_i;
  logic [SeqW-1:0]   seq_number_i;
  logic [ChunkW-1:0] chunk_number_i;
  logic              done_o;
  result_t           seen;
  logic              psel, penable, pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;

  backlog_mirror sb = new();
  int unsigned   stalled_cycles = 0;

  always #1 clk_i = ~clk_i;

  backlog_fifo_watermark_backpressure uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .buffer_ref_i   (buffer_ref_i),
    .seq_number_i   (seq_number_i),
    .chunk_number_i (chunk_number_i),
    .done_o         (done_o),
    .out_valid_o    (seen.valid),
    .out_ref_o      (seen.buf_ref),
    .out_seq_o      (seen.seq),
    .out_chunk_o    (seen.chunk),
    .apply_pulse_o  (seen.apply),
    .release_pulse_o(seen.rel),
    .pressure_on_o  (seen.pressure),
    .backlog_count_o(seen.count),
    .backlog_empty_o(seen.empty),
    .overflow_o     (seen.ovf),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Monitor: note accepted items, check results, and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.apply_event(kind_i, buffer_ref_i, seq_number_i, chunk_number_i);
      if (done_o) sb.match_result(seen);
      if ((start && !busy) || done_o) begin
        stalled_cycles = 0;
      end else if (++stalled_cycles >= StallLimit) begin
        $display("%0t: no item or result for %0d cycles", $time, StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Present one item; call at a falling edge. start stays high on return.
  task automatic drive_event(kind_e k, logic [RefW-1:0] r, logic [SeqW-1:0] s,
                             logic [ChunkW-1:0] c);
    start <= 1'b1;
    kind_i <= k;
    buffer_ref_i <= r;
    seq_number_i <= s;
    chunk_number_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender gap with junk on the payload; n sets its length
  task automatic pause_sender(int n);
    @(negedge clk_i);
    start <= 1'b0;
    kind_i <= 2'($urandom);
    buffer_ref_i <= RefW'($urandom);
    seq_number_i <= $urandom;
    chunk_number_i <= $urandom;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Drop start and wait until every result is back
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup then access; junk above the register width
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] junk;
    junk = $urandom & ((idx == REG_UPPER) ? ~32'h1F : ~32'hF);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value | junk;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_threshold(idx, value | junk);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One random item; mostly new buffers, retries of the pending buffer and
  // write-ok events, some drains and unused kinds
  task automatic issue_random(int fill_pct);
    int          roll;
    logic [31:0] s, c;
    @(negedge clk_i);
    roll = $urandom_range(0, 99);
    s = $urandom;
    c = $urandom;
    if (roll < 3) begin
      drive_event(KIND_UNUSED, RefW'($urandom), s, c);
    end else if (roll < fill_pct) begin
      if (sb.pend_valid && $urandom_range(0, 2) == 0) begin
        s = sb.pend_seq;
        c = sb.pend_chunk;
      end else if (sb.pend_valid && $urandom_range(0, 15) == 0) begin
        s = sb.pend_seq;
      end
      drive_event(KIND_FULL, RefW'($urandom), s, c);
    end else if ($urandom_range(0, 2) != 0) begin
      drive_event(KIND_OK, RefW'($urandom), s, c);
    end else begin
      drive_event(KIND_DRAIN, RefW'($urandom), s, c);
    end
  endtask

  initial begin
    int unsigned upper_set[NumPhases];
    int unsigned lower_set[NumPhases];
    int          fill_pct;
    int          mode_left;

    upper_set = '{1, 16, 8, 0, 31, 4, 5};
    lower_set = '{0, 15, 3, 0, 15, 12, 2};
    rst_ni <= 1'b0;
    start <= 1'b0;
    kind_i <= KIND_FULL;
    buffer_ref_i <= '0;
    seq_number_i <= '0;
    chunk_number_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pops from empty, unused kind, pending match and near-miss,
    // release, then fill until a push overflows
    @(negedge clk_i); drive_event(KIND_DRAIN, 16'h0, 32'h0, 32'h0);
    @(negedge clk_i); drive_event(KIND_OK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(negedge clk_i); drive_event(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(negedge clk_i); drive_event(KIND_FULL, 16'h0, 32'h0, 32'h0);
    @(negedge clk_i); drive_event(KIND_FULL, 16'hFFFF, 32'h0, 32'h0);
    @(negedge clk_i); drive_event(KIND_FULL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(negedge clk_i); drive_event(KIND_FULL, 16'h1234, 32'h0, 32'h1);
    @(negedge clk_i); drive_event(KIND_OK, 16'h0, 32'h0, 32'h0);
    @(negedge clk_i); drive_event(KIND_DRAIN, 16'h0, 32'h0, 32'h0);
    @(negedge clk_i); drive_event(KIND_OK, 16'h0, 32'h0, 32'h0);
    for (int i = 0; i < Depth + 2; i++) begin
      @(negedge clk_i);
      drive_event(KIND_FULL, RefW'($urandom), $urandom, $urandom);
    end
    @(negedge clk_i); drive_event(KIND_UNUSED, 16'h0, 32'h0, 32'h0);
    @(negedge clk_i); drive_event(KIND_DRAIN, 16'h0, 32'h0, 32'h0);

    // Random phases, each under its own threshold pair; the last has no gaps
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(REG_UPPER, upper_set[p]);
      write_reg(REG_LOWER, lower_set[p]);
      fill_pct = 75;
      mode_left = $urandom_range(10, 30);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // swing between filling and draining the backlog
        if (--mode_left == 0) begin
          fill_pct = (fill_pct == 75) ? 30 : 75;
          mode_left = $urandom_range(10, 30);
        end
        if (p != NumPhases - 1 && $urandom_range(0, 7) == 0)
          pause_sender($urandom_range(1, 10));
        issue_random(fill_pct);
      end
    end

    settle();
    if (sb.due_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.due_results.size());
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
